FILE: rtl/core/rtss_pkg.sv
// Shared constants and controller/datapath interface types for the step sequencer.
`default_nettype none
package rtss_pkg;

    localparam int NUM_STEPS_DEF        = 8;
    localparam int ONE_SECOND_TICKS_DEF = 48000;
    localparam int FRAC_BITS_DEF        = 8;

    localparam int PHASE_W = 32;
    localparam int RATIO_W = 30;
    localparam int HOLD_W  = 10;
    localparam int BEAT_W  = 7;
    localparam int DEP_W   = 2;
    localparam int IDX_W   = 3;
    localparam int RATIO_FRAC = 16;

    localparam logic [PHASE_W-1:0] MASTER_PERIOD_RST = 32'd12288000;
    localparam logic [BEAT_W-1:0]  MASTER_LENGTH_RST = 7'd4;
    localparam logic [RATIO_W-1:0] RATIO_ONE         = 30'd65536;
    localparam logic [HOLD_W-1:0]  HOLD_RST          = 10'd4;
    localparam logic [BEAT_W-1:0]  LENGTH_RST        = 7'd2;

    localparam logic [DEP_W-1:0] DEP_MASTER = 2'd0;
    localparam logic [DEP_W-1:0] DEP_PREV   = 2'd1;
    localparam logic [DEP_W-1:0] DEP_BACK2  = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic REG_MASTER_PERIOD = 1'b0;
    localparam logic REG_MASTER_LENGTH = 1'b1;

    typedef struct packed {
        logic load;     // capture input item
        logic add;      // advance both phases one tick
        logic mwrap;    // master wrap, start period multiply
        logic mgate;    // master latch, store step period
        logic swrap;    // step wrap and hold count
        logic sgate;    // step latches, arm step move
        logic search;   // one search step
        logic rstchk;   // reset edge handling
        logic wr_tbl;   // write step table entry
        logic rd_out;   // read period of current step
        logic out_load; // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic is_write;
        logic search_done;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/rtss_datapath.sv
// Datapath: phases, beat counters, step tables, period memory and output register.
`default_nettype none
module rtss_datapath #(
    parameter int NUM_STEPS        = rtss_pkg::NUM_STEPS_DEF,
    parameter int ONE_SECOND_TICKS = rtss_pkg::ONE_SECOND_TICKS_DEF,
    parameter int FRAC_BITS        = rtss_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rtss_pkg::dp_cmd_t   cmd,
    output rtss_pkg::dp_stat_t       stat,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                in_cmd,
    input  wire logic [87:0]         in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [23:0]              out_data
);
    localparam int STEP_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam logic [31:0] PER_RST = 32'(ONE_SECOND_TICKS) << FRAC_BITS;
    localparam logic [32:0] TICK    = 33'd1 << FRAC_BITS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    // configuration
    logic [31:0] mper_reg;
    logic [6:0]  mlen_reg;

    // captured item
    logic        icmd_reg;
    logic        ilevel_reg;
    logic [2:0]  iidx_reg;
    logic        ion_reg;
    logic [1:0]  idep_reg;
    logic [29:0] iratio_reg;
    logic [9:0]  ihold_reg;
    logic [6:0]  ilen_reg;
    logic [6:0]  iacc_reg [4];

    // sequencer state
    logic [31:0] mph_reg, sph_reg;
    logic [6:0]  mbeat_reg, sbeat_reg;
    logic [9:0]  hcnt_reg;
    logic [STEP_W-1:0] cur_reg, srch_reg;
    logic        rlatch_reg;
    logic [2:0]  gl_reg;
    logic        move_reg;

    // step tables
    logic [NUM_STEPS-1:0] on_reg;
    logic [1:0]  dep_reg   [NUM_STEPS];
    logic [29:0] ratio_reg [NUM_STEPS];
    logic [9:0]  hold_reg  [NUM_STEPS];
    logic [6:0]  len_reg   [NUM_STEPS];
    logic [6:0]  acc_reg   [NUM_STEPS][4];

    // period memory
    logic [31:0] per_mem [NUM_STEPS];
    logic [NUM_STEPS-1:0] per_vld_reg;
    logic [31:0] rd_reg;
    logic [61:0] prod_reg;
    logic [31:0] sper_reg;

    // output register
    logic        ovalid_reg;
    logic [23:0] odata_reg;

    // combinational helpers
    logic [1:0]  dep_c;
    logic        use_mem;
    logic [31:0] base;
    logic [STEP_W-1:0] ra;
    logic [31:0] sper_sat;
    logic [32:0] msum, ssum;
    logic [7:0]  mb_inc, sb_inc;
    logic [6:0]  mb_nx, sb_nx;
    logic        mgate_now, pulse, acc_hit;
    logic [STEP_W-1:0] cand;
    logic        hit;
    logic        widx_ok;
    logic [STEP_W-1:0] widx;
    logic [1:0]  wdep;
    logic        og_m, og_s;

    always_comb
    begin
        dep_c   = dep_reg[cur_reg];
        use_mem = (dep_c == rtss_pkg::DEP_PREV  && 32'(cur_reg) >= 32'd1) ||
                  (dep_c == rtss_pkg::DEP_BACK2 && 32'(cur_reg) >= 32'd2);
        base    = use_mem ? rd_reg : mper_reg;
        ra      = cmd.rd_out ? cur_reg : (cur_reg - STEP_W'(dep_c));
        sper_sat = (prod_reg[61:48] != 14'd0) ? 32'hFFFF_FFFF : prod_reg[47:16];
        msum    = {1'b0, mph_reg} + TICK;
        ssum    = {1'b0, sph_reg} + TICK;
        mb_inc  = {1'b0, mbeat_reg} + 8'd1;
        mb_nx   = (mb_inc >= {1'b0, mlen_reg}) ? 7'd0 : mb_inc[6:0];
        sb_inc  = {1'b0, sbeat_reg} + 8'd1;
        sb_nx   = (sb_inc >= {1'b0, len_reg[cur_reg]}) ? 7'd0 : sb_inc[6:0];
        mgate_now = {mph_reg, 1'b0} < {1'b0, mper_reg};
        pulse   = {sph_reg, 1'b0} < {1'b0, sper_reg};
        acc_hit = (sbeat_reg == acc_reg[cur_reg][0]) || (sbeat_reg == acc_reg[cur_reg][1]) ||
                  (sbeat_reg == acc_reg[cur_reg][2]) || (sbeat_reg == acc_reg[cur_reg][3]);
        cand    = (srch_reg == LAST_STEP) ? '0 : srch_reg + 1'b1;
        hit     = on_reg[cand] || (cand == '0);
        widx_ok = 32'(iidx_reg) < 32'(NUM_STEPS);
        widx    = STEP_W'(iidx_reg);
        wdep    = (idep_reg > rtss_pkg::DEP_BACK2 || 32'(idep_reg) > 32'(iidx_reg)) ?
                  rtss_pkg::DEP_MASTER : idep_reg;
        og_m    = mgate_now;
        og_s    = {sph_reg, 1'b0} < {1'b0, rd_reg};
    end

    assign stat.is_write    = icmd_reg;
    assign stat.search_done = !move_reg || hit;
    assign stat.out_free    = !ovalid_reg || out_ready;
    assign out_valid        = ovalid_reg;
    assign out_data         = odata_reg;

    // capture item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            icmd_reg    <= in_cmd;
            ilevel_reg  <= in_data[0];
            iidx_reg    <= in_data[3:1];
            ion_reg     <= in_data[4];
            idep_reg    <= in_data[6:5];
            iratio_reg  <= in_data[36:7];
            ihold_reg   <= in_data[46:37];
            ilen_reg    <= in_data[53:47];
            iacc_reg[0] <= in_data[60:54];
            iacc_reg[1] <= in_data[67:61];
            iacc_reg[2] <= in_data[74:68];
            iacc_reg[3] <= in_data[81:75];
        end
    end

    // period memory: registered read, valid bits stand in for reset contents
    always_ff @(posedge clk)
    begin
        if (cmd.add || cmd.rd_out)
            rd_reg <= per_vld_reg[ra] ? per_mem[ra] : PER_RST;
        if (cmd.mgate)
            per_mem[cur_reg] <= sper_sat;
    end

    // multiply and period hold
    always_ff @(posedge clk)
    begin
        if (cmd.mwrap)
            prod_reg <= 62'(ratio_reg[cur_reg]) * 62'(base);
        if (cmd.mgate)
            sper_reg <= sper_sat;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            odata_reg <= {2'b00, mbeat_reg, sbeat_reg, 3'(cur_reg),
                          gl_reg[2], gl_reg[1], og_s, gl_reg[0], og_m};
    end

    // control state, tables and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mper_reg    <= rtss_pkg::MASTER_PERIOD_RST;
            mlen_reg    <= rtss_pkg::MASTER_LENGTH_RST;
            mph_reg     <= '0;
            sph_reg     <= '0;
            mbeat_reg   <= '0;
            sbeat_reg   <= '0;
            hcnt_reg    <= '0;
            cur_reg     <= '0;
            srch_reg    <= '0;
            rlatch_reg  <= 1'b0;
            gl_reg      <= '0;
            move_reg    <= 1'b0;
            per_vld_reg <= '0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_STEPS; i++)
            begin
                on_reg[i]    <= (i == 0);
                dep_reg[i]   <= rtss_pkg::DEP_MASTER;
                ratio_reg[i] <= rtss_pkg::RATIO_ONE;
                hold_reg[i]  <= rtss_pkg::HOLD_RST;
                len_reg[i]   <= rtss_pkg::LENGTH_RST;
                for (int k = 0; k < 4; k++)
                    acc_reg[i][k] <= '0;
            end
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                if (cfg_addr == rtss_pkg::REG_MASTER_PERIOD)
                    mper_reg <= cfg_wdata;
                else
                    mlen_reg <= cfg_wdata[6:0];
            end

            // advance phases, saturate at full scale
            if (cmd.add)
            begin
                mph_reg <= msum[32] ? 32'hFFFF_FFFF : msum[31:0];
                sph_reg <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
            end

            // master wrap
            if (cmd.mwrap && mph_reg >= mper_reg)
            begin
                mph_reg   <= mph_reg - mper_reg;
                mbeat_reg <= mb_nx;
            end

            // master downbeat latch, store step period
            if (cmd.mgate)
            begin
                if (mbeat_reg == 7'd0)
                    gl_reg[0] <= mgate_now;
                per_vld_reg[cur_reg] <= 1'b1;
            end

            // step wrap
            if (cmd.swrap && sph_reg >= sper_reg)
            begin
                hcnt_reg  <= (hold_reg[cur_reg] != 10'd0) ? hcnt_reg + 10'd1 : 10'd0;
                sph_reg   <= sph_reg - sper_reg;
                sbeat_reg <= sb_nx;
            end

            // step latches, arm move
            if (cmd.sgate)
            begin
                if (sbeat_reg == 7'd0)
                    gl_reg[1] <= pulse;
                else if (acc_hit)
                    gl_reg[2] <= pulse;
                srch_reg <= cur_reg;
                if (hcnt_reg >= hold_reg[cur_reg] && hcnt_reg != 10'd0)
                begin
                    move_reg <= 1'b1;
                    hcnt_reg <= '0;
                end
                else
                    move_reg <= 1'b0;
            end

            // search next enabled step
            if (cmd.search && move_reg)
            begin
                srch_reg <= cand;
                if (hit)
                begin
                    cur_reg  <= cand;
                    move_reg <= 1'b0;
                end
            end

            // reset edge
            if (cmd.rstchk)
            begin
                if (rlatch_reg)
                begin
                    if (!ilevel_reg)
                        rlatch_reg <= 1'b0;
                end
                else if (ilevel_reg)
                begin
                    rlatch_reg <= 1'b1;
                    cur_reg    <= '0;
                    mph_reg    <= '0;
                    sph_reg    <= '0;
                    hcnt_reg   <= '0;
                    mbeat_reg  <= '0;
                    sbeat_reg  <= '0;
                    gl_reg[2]  <= 1'b0;
                end
            end

            // table write
            if (cmd.wr_tbl && widx_ok)
            begin
                on_reg[widx]    <= (widx == '0) ? 1'b1 : ion_reg;
                dep_reg[widx]   <= wdep;
                ratio_reg[widx] <= iratio_reg;
                hold_reg[widx]  <= ihold_reg;
                len_reg[widx]   <= ilen_reg;
                for (int k = 0; k < 4; k++)
                    acc_reg[widx][k] <= iacc_reg[k];
            end

            // output valid
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/rtss_ctrl.sv
// Controller: sequences one item through the datapath steps.
`default_nettype none
module rtss_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rtss_pkg::dp_stat_t stat,
    output rtss_pkg::dp_cmd_t       cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ADD    = 4'd1;
    localparam logic [3:0] ST_MWRAP  = 4'd2;
    localparam logic [3:0] ST_MGATE  = 4'd3;
    localparam logic [3:0] ST_SWRAP  = 4'd4;
    localparam logic [3:0] ST_SGATE  = 4'd5;
    localparam logic [3:0] ST_SEARCH = 4'd6;
    localparam logic [3:0] ST_RSTCHK = 4'd7;
    localparam logic [3:0] ST_WRITE  = 4'd8;
    localparam logic [3:0] ST_RDOUT  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (stat.is_write)
                    state_next = ST_WRITE;
                else
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_MWRAP;
                end
            end
            ST_MWRAP:
            begin
                cmd.mwrap  = 1'b1;
                state_next = ST_MGATE;
            end
            ST_MGATE:
            begin
                cmd.mgate  = 1'b1;
                state_next = ST_SWRAP;
            end
            ST_SWRAP:
            begin
                cmd.swrap  = 1'b1;
                state_next = ST_SGATE;
            end
            ST_SGATE:
            begin
                cmd.sgate  = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.search_done)
                    state_next = ST_RSTCHK;
            end
            ST_RSTCHK:
            begin
                cmd.rstchk = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_WRITE:
            begin
                cmd.wr_tbl = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                cmd.rd_out = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/ratio_tempo_step_sequencer.sv
// Top level of the ratio tempo step sequencer.
// Each input item is either one clock tick or a write of one step table entry, and
// gives exactly one result item with the gates, active step and beat counts. A tick
// runs add, master wrap, master gate, step wrap, step gate, next-step search, reset
// check, period read-out and output load, as the controller walks the shared period
// multiplier, the single-port period memory and the one-step-per-cycle search. A table
// write runs table write, period read-out and output load. The next item is taken
// while a result waits in the output register. Configuration: index 0 master period
// (Q24.8 ticks), index 1 master measure length; write only while the block is idle.
`default_nettype none
module ratio_tempo_step_sequencer #(
    parameter int NUM_STEPS        = rtss_pkg::NUM_STEPS_DEF,
    parameter int ONE_SECOND_TICKS = rtss_pkg::ONE_SECOND_TICKS_DEF,
    parameter int FRAC_BITS        = rtss_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // reset_level, step_index[3], step_on, step_dep[2], step_ratio[30], step_hold[10],
    // step_length[7], accent_first[7], accent_second[7], accent_third[7],
    // accent_fourth[7], zero fill
    input  wire logic [87:0] s_axis_tdata,
    // cmd
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // master_gate, master_downbeat_gate, step_clock_gate, step_downbeat_gate,
    // accent_gate, active_step[3], step_beat_now[7], master_beat_now[7], zero fill
    output logic [23:0]      m_axis_tdata
);
    rtss_pkg::dp_cmd_t  cmd;
    rtss_pkg::dp_stat_t stat;

    rtss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtss_datapath #(
        .NUM_STEPS        (NUM_STEPS),
        .ONE_SECOND_TICKS (ONE_SECOND_TICKS),
        .FRAC_BITS        (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );
endmodule
`default_nettype wire

FILE: test/ratio_tempo_step_sequencer_tb.sv
// Self-checking testbench for the ratio tempo step sequencer: directed table, then random phases.
`default_nettype none
module ratio_tempo_step_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtss_pkg::*;

    localparam int NSTEP = NUM_STEPS_DEF;
    localparam logic [31:0] PERIOD_RST = 32'(ONE_SECOND_TICKS_DEF) << FRAC_BITS_DEF;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // reset_level, step_index[3], step_on, step_dep[2], step_ratio[30], step_hold[10],
    // step_length[7], accent_first[7], accent_second[7], accent_third[7],
    // accent_fourth[7], zero fill
    logic [87:0] s_axis_tdata;
    // cmd
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // master_gate, master_downbeat_gate, step_clock_gate, step_downbeat_gate,
    // accent_gate, active_step[3], step_beat_now[7], master_beat_now[7], zero fill
    logic [23:0] m_axis_tdata;

    ratio_tempo_step_sequencer dut (.*);

    // Sequencer state mirrored for prediction
    logic [31:0] seq_master_period;
    logic [6:0]  seq_master_length;
    logic [31:0] master_ph;
    logic [31:0] step_ph;
    logic [6:0]  master_cnt;
    logic [6:0]  step_cnt;
    logic [9:0]  hold_cnt;
    logic [2:0]  playing;
    logic        rst_seen;
    logic [2:0]  latches;
    logic        tbl_on    [NSTEP];
    logic [1:0]  tbl_dep   [NSTEP];
    logic [29:0] tbl_ratio [NSTEP];
    logic [9:0]  tbl_hold  [NSTEP];
    logic [6:0]  tbl_len   [NSTEP];
    logic [6:0]  tbl_acc   [NSTEP][4];
    logic [31:0] tbl_period[NSTEP];

    logic [23:0] expected_results[$];
    int          errors;
    int          burst_left;
    bit          gaps_on;
    int          rx_mode;
    bit          hold_off_req;
    int          hold_off_cnt;
    int          rx_cyc;
    bit          level;

    typedef struct {
        logic        cmd;
        logic [87:0] data;
        bit          typed;
        logic [23:0] result;
    } stim_row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("ratio_tempo_step_sequencer: mismatch");
        $finish;
    end

    function automatic logic [31:0] sat_tick(logic [31:0] ph);
        logic [32:0] v;
        v = {1'b0, ph} + 33'(1 << FRAC_BITS_DEF);
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic half_high(logic [31:0] ph, logic [31:0] per);
        return {ph, 1'b0} < {1'b0, per};
    endfunction

    function automatic logic [6:0] beat_after(logic [6:0] cnt, logic [6:0] len);
        logic [7:0] n;
        n = {1'b0, cnt} + 8'd1;
        return (n >= {1'b0, len}) ? 7'd0 : n[6:0];
    endfunction

    function automatic logic [87:0] pack_entry(logic lvl, logic [2:0] idx, logic on,
                                               logic [1:0] dep, logic [29:0] ratio,
                                               logic [9:0] hold, logic [6:0] len,
                                               logic [6:0] a0, logic [6:0] a1,
                                               logic [6:0] a2, logic [6:0] a3);
        return {6'd0, a3, a2, a1, a0, len, hold, ratio, dep, on, idx, lvl};
    endfunction

    function automatic logic [23:0] seq_outputs();
        return {2'd0, master_cnt, step_cnt, playing, latches[2], latches[1],
                half_high(step_ph, tbl_period[playing]), latches[0],
                half_high(master_ph, seq_master_period)};
    endfunction

    task automatic seq_clear();
        seq_master_period = MASTER_PERIOD_RST;
        seq_master_length = MASTER_LENGTH_RST;
        master_ph = '0;
        step_ph = '0;
        master_cnt = '0;
        step_cnt = '0;
        hold_cnt = '0;
        playing = '0;
        rst_seen = 1'b0;
        latches = '0;
        for (int i = 0; i < NSTEP; i++)
        begin
            tbl_on[i] = (i == 0);
            tbl_dep[i] = DEP_MASTER;
            tbl_ratio[i] = RATIO_ONE;
            tbl_hold[i] = HOLD_RST;
            tbl_len[i] = LENGTH_RST;
            for (int k = 0; k < 4; k++)
                tbl_acc[i][k] = '0;
            tbl_period[i] = PERIOD_RST;
        end
    endtask

    // Compute the result of one accepted item and advance the mirrored state
    function automatic logic [23:0] seq_predict(logic cmd, logic [87:0] d);
        logic [2:0]  idx;
        logic [1:0]  dep;
        logic [2:0]  c;
        logic [31:0] base;
        logic [63:0] prod;
        logic [31:0] sper;
        logic        mg;
        logic        pulse;
        logic [2:0]  n;
        idx = d[3:1];
        dep = d[6:5];
        c = playing;
        if (cmd == CMD_WRITE)
        begin
            if (dep > DEP_BACK2 || dep > idx)
                dep = DEP_MASTER;
            tbl_on[idx] = (idx == 0) ? 1'b1 : d[4];
            tbl_dep[idx] = dep;
            tbl_ratio[idx] = d[36:7];
            tbl_hold[idx] = d[46:37];
            tbl_len[idx] = d[53:47];
            tbl_acc[idx][0] = d[60:54];
            tbl_acc[idx][1] = d[67:61];
            tbl_acc[idx][2] = d[74:68];
            tbl_acc[idx][3] = d[81:75];
            return seq_outputs();
        end
        // Advance both phases
        master_ph = sat_tick(master_ph);
        step_ph = sat_tick(step_ph);
        if (master_ph >= seq_master_period)
        begin
            master_ph -= seq_master_period;
            master_cnt = beat_after(master_cnt, seq_master_length);
        end
        mg = half_high(master_ph, seq_master_period);
        if (master_cnt == 0)
            latches[0] = mg;
        // Step period from its base
        if (tbl_dep[c] == DEP_PREV && c >= 1)
            base = tbl_period[c - 1];
        else if (tbl_dep[c] == DEP_BACK2 && c >= 2)
            base = tbl_period[c - 2];
        else
            base = seq_master_period;
        prod = (64'(tbl_ratio[c]) * 64'(base)) >> RATIO_FRAC;
        sper = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        tbl_period[c] = sper;
        if (step_ph >= sper)
        begin
            hold_cnt = (tbl_hold[c] > 0) ? hold_cnt + 10'd1 : 10'd0;
            step_ph -= sper;
            step_cnt = beat_after(step_cnt, tbl_len[c]);
        end
        pulse = half_high(step_ph, sper);
        if (step_cnt == 0)
            latches[1] = pulse;
        else if (step_cnt == tbl_acc[c][0] || step_cnt == tbl_acc[c][1] ||
                 step_cnt == tbl_acc[c][2] || step_cnt == tbl_acc[c][3])
            latches[2] = pulse;
        // Move on to the next enabled step
        if (hold_cnt >= tbl_hold[c] && hold_cnt != 0)
        begin
            hold_cnt = '0;
            n = c;
            for (int k = 0; k < NSTEP; k++)
            begin
                n = n + 3'd1;
                if (tbl_on[n] || n == 0)
                    break;
            end
            playing = n;
        end
        // Restart on a rising reset request
        if (rst_seen)
        begin
            if (!d[0])
                rst_seen = 1'b0;
        end
        else if (d[0])
        begin
            rst_seen = 1'b1;
            playing = '0;
            master_ph = '0;
            step_ph = '0;
            hold_cnt = '0;
            master_cnt = '0;
            step_cnt = '0;
            latches[2] = 1'b0;
        end
        return seq_outputs();
    endfunction

    // Offer one item in bursts with random gaps; leave tvalid high on return
    task automatic send_item(logic cmd, logic [87:0] d, bit typed, logic [23:0] res);
        int gap;
        logic [23:0] pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        pred = seq_predict(cmd, d);
        expected_results.push_back(typed ? res : pred);
    endtask

    task automatic write_reg(logic addr, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_MASTER_PERIOD)
            seq_master_period = value;
        else
            seq_master_length = value[6:0];
    endtask

    // Drop valid and wait until the block has drained
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_write();
        logic [29:0] ratio;
        logic [9:0]  hold;
        logic [6:0]  len;
        logic [6:0]  acc[4];
        case ($urandom_range(0, 7))
            0: ratio = 30'($urandom);
            1: ratio = 30'($urandom_range(1, 255));
            default: ratio = 30'($urandom_range(32'h4000, 32'h20000));
        endcase
        hold = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(0, 4));
        len = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(2, 8));
        for (int k = 0; k < 4; k++)
            acc[k] = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 8));
        send_item(CMD_WRITE, pack_entry(1'($urandom), 3'($urandom), 1'($urandom),
                  2'($urandom), ratio, hold, len, acc[0], acc[1], acc[2], acc[3]),
                  1'b0, '0);
    endtask

    task automatic random_tick();
        if ($urandom_range(0, 19) == 0)
            level = ~level;
        send_item(CMD_TICK, 88'({$urandom, $urandom, $urandom})
                  & 88'hFF_FFFF_FFFF_FFFF_FFFF_FFFE | 88'(level), 1'b0, '0);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        logic [23:0] e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("master_gate", e[0], m_axis_tdata[0]);
                check_field("master_downbeat_gate", e[1], m_axis_tdata[1]);
                check_field("step_clock_gate", e[2], m_axis_tdata[2]);
                check_field("step_downbeat_gate", e[3], m_axis_tdata[3]);
                check_field("accent_gate", e[4], m_axis_tdata[4]);
                check_field("active_step", e[7:5], m_axis_tdata[7:5]);
                check_field("step_beat_now", e[14:8], m_axis_tdata[14:8]);
                check_field("master_beat_now", e[21:15], m_axis_tdata[21:15]);
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cnt = 0;
            rx_cyc = 0;
        end
        else
        begin
            rx_cyc++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_off_cnt = 400;
            end
            if (hold_off_cnt > 0)
            begin
                hold_off_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ((rx_cyc % 11) < 6);
                endcase
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [31:0] periods[6];
        logic [6:0]  lengths[6];
        errors = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        rx_mode = 1;
        hold_off_req = 1'b0;
        level = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= REG_MASTER_PERIOD;
        cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= CMD_TICK;
        s_axis_tdata <= '0;
        seq_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: write after reset shows both phase gates high
        rows.push_back('{CMD_WRITE, pack_entry(0, 1, 1, DEP_PREV, RATIO_ONE, 1, 3, 1, 2, 0, 0),
                         1'b1, 24'h000005});
        rows.push_back('{CMD_TICK, 88'd0, 1'b0, '0});
        rows.push_back('{CMD_WRITE, pack_entry(0, 0, 0, DEP_BACK2, 30'd1, 0, 0, 0, 0, 0, 0),
                         1'b0, '0});
        rows.push_back('{CMD_WRITE, pack_entry(1, 7, 1, DEP_BACK2, 30'h3FFF_FFFF, 900, 100,
                                               99, 99, 99, 99), 1'b0, '0});
        rows.push_back('{CMD_WRITE, pack_entry(0, 2, 1, 2'd3, RATIO_ONE, 1023, 127,
                                               127, 127, 127, 127), 1'b0, '0});
        rows.push_back('{CMD_WRITE, pack_entry(0, 0, 1, DEP_MASTER, 30'd256, 1, 1, 0, 0, 0, 0),
                         1'b0, '0});
        for (int i = 0; i < 6; i++)
            rows.push_back('{CMD_TICK, 88'd0, 1'b0, '0});
        rows.push_back('{CMD_TICK, 88'd1, 1'b0, '0});
        rows.push_back('{CMD_TICK, 88'd1, 1'b0, '0});
        rows.push_back('{CMD_TICK, 88'd0, 1'b0, '0});
        rows.push_back('{CMD_TICK, 88'd1, 1'b0, '0});
        rows.push_back('{CMD_WRITE, pack_entry(1, 0, 1, DEP_MASTER, RATIO_ONE, 2, 2, 1, 0, 0, 0),
                         1'b0, '0});
        for (int i = 0; i < 4; i++)
            rows.push_back('{CMD_TICK, 88'd0, 1'b0, '0});
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].result);
        drain();

        // Random phases, each with its own register setting
        periods = '{MASTER_PERIOD_RST, 32'd256, 32'd868, 32'hFFFF_FFFF, 32'd1792, 32'd512};
        lengths = '{MASTER_LENGTH_RST, 7'd2, 7'd100, 7'd3, 7'd127, 7'd1};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_MASTER_PERIOD, periods[p]);
            write_reg(REG_MASTER_LENGTH, lengths[p]);
            gaps_on = (p != 3);
            rx_mode = p % 3;
            if (p == 2)
                hold_off_req = 1'b1;
            for (int k = 0; k < 4; k++)
                random_write();
            for (int k = 0; k < 268; k++)
                if ($urandom_range(0, 9) == 0)
                    random_write();
                else
                    random_tick();
            drain();
        end

        if (errors == 0)
            $display("ratio_tempo_step_sequencer: match");
        else
            $display("ratio_tempo_step_sequencer: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
